FILE: rtl/core/sacv_pkg.sv
// Shared types, constants and hash round functions of the SYN-ACK cookie validator.
// No dependencies; used by sacv_front, sacv_back and the top level in rtl/core.
package sacv_pkg;

    // Frame screening
    localparam logic [11:0] MIN_FRAME_BYTES = 12'd54;
    localparam logic [7:0]  PROTO_TCP       = 8'd6;

    // Seen table geometry, front-to-back queue depth and hash pipeline depth
    localparam int TABLE_WAYS  = 4;
    localparam int KEY_W       = 48;
    localparam int ROW_W       = TABLE_WAYS * KEY_W;
    localparam int QUEUE_DEPTH = 16;
    localparam int PIPE_STAGES = 12;

    // Configuration register indexes
    localparam logic CFG_KEY_LOW  = 1'b0;
    localparam logic CFG_KEY_HIGH = 1'b1;

    // Hash initialisation and finalisation constants
    localparam logic [63:0] SIP_C0 = 64'h736f6d6570736575;
    localparam logic [63:0] SIP_C1 = 64'h646f72616e646f6d;
    localparam logic [63:0] SIP_C2 = 64'h6c7967656e657261;
    localparam logic [63:0] SIP_C3 = 64'h7465646279746573;
    localparam logic [63:0] SIP_FIN = 64'h00000000000000ff;

    typedef enum logic [2:0] {
        VERDICT_IGNORED    = 3'd0,
        VERDICT_NOT_SYNACK = 3'd1,
        VERDICT_BAD_COOKIE = 3'd2,
        VERDICT_DUPLICATE  = 3'd3,
        VERDICT_NEW_OPEN   = 3'd4
    } t_verdict;

    typedef enum logic [1:0] {
        CLS_IGNORE,
        CLS_NOT_SYNACK,
        CLS_SYNACK
    } t_class;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CHECK
    } t_back_state;

    typedef struct packed {
        logic [63:0] v0;
        logic [63:0] v1;
        logic [63:0] v2;
        logic [63:0] v3;
    } t_sip_state;

    // Classified item handed from front to back
    typedef struct packed {
        t_class      cls;
        logic        cookie_ok;
        logic [31:0] ip;
        logic [15:0] port;
    } t_item;

    function automatic logic [63:0] rotl(logic [63:0] x, int b);
        return (x << b) | (x >> (64 - b));
    endfunction

    // First half of a round: two independent 64-bit adds
    function automatic t_sip_state sip_half_a(t_sip_state s);
        t_sip_state o;
        o    = s;
        o.v0 = s.v0 + s.v1;
        o.v1 = rotl(s.v1, 13) ^ o.v0;
        o.v0 = rotl(o.v0, 32);
        o.v2 = s.v2 + s.v3;
        o.v3 = rotl(s.v3, 16) ^ o.v2;
        return o;
    endfunction

    // Second half of a round
    function automatic t_sip_state sip_half_b(t_sip_state s);
        t_sip_state o;
        o    = s;
        o.v0 = s.v0 + s.v3;
        o.v3 = rotl(s.v3, 21) ^ o.v0;
        o.v2 = s.v2 + s.v1;
        o.v1 = rotl(s.v1, 17) ^ o.v2;
        o.v2 = rotl(o.v2, 32);
        return o;
    endfunction

endpackage

FILE: rtl/core/sacv_queue.sv
// Small register FIFO between the front and back parts of the validator.
// Depends on nothing; overflow is prevented by the front's credit count.
module sacv_queue #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_data
);
    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr;
    logic [PW-1:0]    r_rd;
    logic [CW-1:0]    r_count;
    logic             do_pop;

    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd];
    assign do_pop  = i_pop && !o_empty;

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            r_count <= r_count + CW'(i_push) - CW'(do_pop);
        end
    end
endmodule

FILE: rtl/core/sacv_front.sv
// Front part: screens each frame, runs the keyed hash over 12 half-round stages
// and reduces the key to a table slot. Depends on sacv_pkg.
module sacv_front
    import sacv_pkg::*;
#(
    parameter int TABLE_SLOTS = 4096,
    parameter int SW          = $clog2(TABLE_SLOTS)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  logic [11:0]   i_frame_length,
    input  logic [7:0]    i_ip_protocol,
    input  logic          i_syn_flag,
    input  logic          i_ack_flag,
    input  logic [31:0]   i_source_ip,
    input  logic [15:0]   i_source_port,
    input  logic [31:0]   i_ack_number,
    input  logic [63:0]   i_key_low,
    input  logic [63:0]   i_key_high,
    input  logic          i_credit_ret,
    output logic          o_busy,
    output logic          o_q_push,
    output t_item         o_q_item,
    output logic [SW-1:0] o_q_slot
);
    localparam int CRW = $clog2(QUEUE_DEPTH + 1);

    // key mod TABLE_SLOTS, one nibble per stage
    function automatic logic [SW-1:0] rem_step(logic [SW-1:0] r, logic [3:0] nib);
        logic [SW+3:0] t;
        t = {r, nib};
        for (int k = 3; k >= 0; k--) begin
            if (t >= ((SW+4)'(TABLE_SLOTS) << k)) begin
                t = t - ((SW+4)'(TABLE_SLOTS) << k);
            end
        end
        return t[SW-1:0];
    endfunction

    logic          r_vld  [PIPE_STAGES+1];
    t_sip_state    r_st   [PIPE_STAGES+1];
    t_class        r_cls  [PIPE_STAGES+1];
    logic [31:0]   r_ip   [PIPE_STAGES+1];
    logic [15:0]   r_port [PIPE_STAGES+1];
    logic [31:0]   r_ack  [PIPE_STAGES+1];
    logic [SW-1:0] r_rem  [PIPE_STAGES+1];
    logic [CRW-1:0] r_inflight;

    t_class      in_cls;
    logic [63:0] in_m;
    logic [31:0] hash_lo;

    // Screening of the incoming header
    always_comb begin
        in_m = {16'd0, i_source_ip, i_source_port};
        if (i_frame_length < MIN_FRAME_BYTES || i_ip_protocol != PROTO_TCP) begin
            in_cls = CLS_IGNORE;
        end else if (!i_syn_flag || !i_ack_flag) begin
            in_cls = CLS_NOT_SYNACK;
        end else begin
            in_cls = CLS_SYNACK;
        end
    end

    // Entry stage: hash initialisation with the message folded into v3
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else begin
            r_vld[0] <= i_accept;
        end
        r_st[0].v0 <= i_key_low ^ SIP_C0;
        r_st[0].v1 <= i_key_high ^ SIP_C1;
        r_st[0].v2 <= i_key_low ^ SIP_C2;
        r_st[0].v3 <= i_key_high ^ SIP_C3 ^ in_m;
        r_cls[0]   <= in_cls;
        r_ip[0]    <= i_source_ip;
        r_port[0]  <= i_source_port;
        r_ack[0]   <= i_ack_number;
        r_rem[0]   <= '0;
    end

    // Half-round stages; message folded into v0 after the two compression rounds
    for (genvar s = 1; s <= PIPE_STAGES; s++) begin : g_stage
        t_sip_state st_in;
        logic [47:0] key;

        always_comb begin
            key   = {r_ip[s-1], r_port[s-1]};
            st_in = r_st[s-1];
            if (s == 5) begin
                st_in.v0 = st_in.v0 ^ {16'd0, key};
                st_in.v2 = st_in.v2 ^ SIP_FIN;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else begin
                r_vld[s] <= r_vld[s-1];
            end
            r_st[s]   <= ((s % 2) == 1) ? sip_half_a(st_in) : sip_half_b(st_in);
            r_cls[s]  <= r_cls[s-1];
            r_ip[s]   <= r_ip[s-1];
            r_port[s] <= r_port[s-1];
            r_ack[s]  <= r_ack[s-1];
            r_rem[s]  <= rem_step(r_rem[s-1], key[KEY_W-1-4*(s-1) -: 4]);
        end
    end

    // Final fold and cookie compare
    assign hash_lo = r_st[PIPE_STAGES].v0[31:0] ^ r_st[PIPE_STAGES].v1[31:0]
                   ^ r_st[PIPE_STAGES].v2[31:0] ^ r_st[PIPE_STAGES].v3[31:0];

    always_comb begin
        o_q_push           = r_vld[PIPE_STAGES];
        o_q_item.cls       = r_cls[PIPE_STAGES];
        o_q_item.cookie_ok = (r_ack[PIPE_STAGES] == hash_lo + 32'd1);
        o_q_item.ip        = r_ip[PIPE_STAGES];
        o_q_item.port      = r_port[PIPE_STAGES];
        o_q_slot           = r_rem[PIPE_STAGES];
    end

    // Credits: items in the pipeline plus items in the queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight <= '0;
        end else begin
            r_inflight <= r_inflight + CRW'(i_accept) - CRW'(i_credit_ret);
        end
    end

    assign o_busy = (r_inflight == CRW'(QUEUE_DEPTH));
endmodule

FILE: rtl/core/sacv_back.sv
// Back part: clears and owns the seen table, removes duplicates, keeps the
// counters and holds the result register. Depends on sacv_pkg.
module sacv_back
    import sacv_pkg::*;
#(
    parameter int TABLE_SLOTS = 4096,
    parameter int SW          = $clog2(TABLE_SLOTS)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_empty,
    input  t_item         i_q_item,
    input  logic [SW-1:0] i_q_slot,
    output logic          o_q_pop,
    output logic          o_clearing,
    output logic          o_valid,
    input  logic          i_pop,
    output logic [2:0]    o_verdict,
    output logic          o_port_open,
    output logic [31:0]   o_open_ip,
    output logic [15:0]   o_open_port,
    output logic [31:0]   o_reply_count,
    output logic [31:0]   o_open_count
);
    logic [ROW_W-1:0] r_mem [TABLE_SLOTS];
    logic [ROW_W-1:0] r_rd_row;

    t_back_state r_state, n_state;
    logic [SW-1:0] r_clr;
    logic [SW-1:0] r_cur_slot;
    logic [31:0]   r_cur_ip;
    logic [15:0]   r_cur_port;
    logic [1:0]    r_way, n_way;
    logic [31:0]   r_replies, n_replies;
    logic [31:0]   r_opens, n_opens;
    logic          r_out_valid;

    logic             out_free;
    logic             emit;
    t_verdict         emit_verdict;
    logic             latch_cur;
    logic             mem_we;
    logic [SW-1:0]    mem_wa;
    logic [ROW_W-1:0] mem_wd;
    logic [SW-1:0]    rd_addr;
    logic [47:0]      cur_key;
    logic             hit;

    assign out_free = !r_out_valid || i_pop;
    assign cur_key  = {r_cur_ip, r_cur_port};
    assign rd_addr  = (r_state == ST_IDLE) ? i_q_slot : r_cur_slot;

    always_comb begin
        hit = 1'b0;
        for (int w = 0; w < TABLE_WAYS; w++) begin
            if (r_rd_row[w*KEY_W +: KEY_W] == cur_key) begin
                hit = 1'b1;
            end
        end
    end

    // Next state, table access and result selection
    always_comb begin
        n_state      = r_state;
        n_way        = r_way;
        n_replies    = r_replies;
        n_opens      = r_opens;
        o_q_pop      = 1'b0;
        emit         = 1'b0;
        emit_verdict = VERDICT_IGNORED;
        latch_cur    = 1'b0;
        mem_we       = 1'b0;
        mem_wa       = r_cur_slot;
        mem_wd       = r_rd_row;
        unique case (r_state)
            ST_CLEAR: begin
                mem_we = 1'b1;
                mem_wa = r_clr;
                mem_wd = '0;
                if (r_clr == SW'(TABLE_SLOTS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (!i_q_empty) begin
                    if (i_q_item.cls == CLS_SYNACK && i_q_item.cookie_ok) begin
                        o_q_pop   = 1'b1;
                        latch_cur = 1'b1;
                        n_state   = ST_CHECK;
                    end else if (out_free) begin
                        o_q_pop = 1'b1;
                        emit    = 1'b1;
                        unique case (i_q_item.cls)
                            CLS_IGNORE:     emit_verdict = VERDICT_IGNORED;
                            CLS_NOT_SYNACK: emit_verdict = VERDICT_NOT_SYNACK;
                            default: begin
                                emit_verdict = VERDICT_BAD_COOKIE;
                                if (r_replies != '1) begin
                                    n_replies = r_replies + 32'd1;
                                end
                            end
                        endcase
                    end
                end
            end
            ST_CHECK: begin
                if (out_free) begin
                    emit    = 1'b1;
                    n_state = ST_IDLE;
                    if (r_replies != '1) begin
                        n_replies = r_replies + 32'd1;
                    end
                    if (hit) begin
                        emit_verdict = VERDICT_DUPLICATE;
                    end else begin
                        emit_verdict = VERDICT_NEW_OPEN;
                        mem_we       = 1'b1;
                        mem_wd[r_way*KEY_W +: KEY_W] = cur_key;
                        n_way        = r_way + 2'd1;
                        if (r_opens != '1) begin
                            n_opens = r_opens + 32'd1;
                        end
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Seen table, registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_rd_row <= r_mem[rd_addr];
    end

    // Control state and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr       <= '0;
            r_way       <= '0;
            r_replies   <= '0;
            r_opens     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_way     <= n_way;
            r_replies <= n_replies;
            r_opens   <= n_opens;
            if (r_state == ST_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Item under lookup and result register payload
    always_ff @(posedge i_clk) begin
        if (latch_cur) begin
            r_cur_slot <= i_q_slot;
            r_cur_ip   <= i_q_item.ip;
            r_cur_port <= i_q_item.port;
        end
        if (emit) begin
            o_verdict     <= emit_verdict;
            o_port_open   <= (emit_verdict == VERDICT_NEW_OPEN);
            o_open_ip     <= (emit_verdict == VERDICT_NEW_OPEN) ? r_cur_ip : 32'd0;
            o_open_port   <= (emit_verdict == VERDICT_NEW_OPEN) ? r_cur_port : 16'd0;
            o_reply_count <= n_replies;
            o_open_count  <= n_opens;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_clearing = (r_state == ST_CLEAR);
endmodule

FILE: rtl/core/syn_ack_cookie_validator.sv
// Top level of the SYN-ACK cookie validator: key registers, front, queue, back.
// Depends on sacv_pkg, sacv_front, sacv_queue and sacv_back.
//
// Usage: header fields of one received frame are written with push while full
// is low. One result per frame comes out in order; it is on the o_ ports
// while empty is low and leaves with pop. Keys are written through i_cfg_we,
// i_cfg_addr (0 low word, 1 high word) and i_cfg_data while the block is idle.
// Path: between the accepting edge and empty falling lie the entry register,
// twelve half-round hash stages, the queue write and the back decision; a valid
// cookie adds the table read. Throughput: one frame per cycle for frames that
// skip the table while pop keeps the output free; a valid cookie holds the back
// part, taking no new item, through the table read and the check and update.
// Reset: after reset the seen table is swept to zero, one slot per cycle, for
// all TABLE_SLOTS slots; full stays high during the sweep, key writes are taken.
// Stalls: a result held by a low pop waits in the output register while up
// to 16 further frames fill the hash pipeline and the queue, plus one valid
// cookie that may wait in the table lookup; then full rises.
module syn_ack_cookie_validator
    import sacv_pkg::*;
#(
    parameter int TABLE_SLOTS = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [11:0] i_frame_length,
    input  logic [7:0]  i_ip_protocol,
    input  logic        i_syn_flag,
    input  logic        i_ack_flag,
    input  logic [31:0] i_source_ip,
    input  logic [15:0] i_source_port,
    input  logic [31:0] i_ack_number,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  o_verdict,
    output logic        o_port_open,
    output logic [31:0] o_open_ip,
    output logic [15:0] o_open_port,
    output logic [31:0] o_reply_count,
    output logic [31:0] o_open_count,
    input  logic        i_cfg_we,
    input  logic        i_cfg_addr,
    input  logic [63:0] i_cfg_data
);
    localparam int SW   = $clog2(TABLE_SLOTS);
    localparam int QW   = $bits(t_item) + SW;

    logic [63:0]   r_key_low;
    logic [63:0]   r_key_high;
    logic          accept;
    logic          front_busy;
    logic          clearing;
    logic          fq_push;
    t_item         fq_item;
    logic [SW-1:0] fq_slot;
    logic          q_pop;
    logic          q_empty;
    logic [QW-1:0] q_data;
    logic          out_valid;

    // Key registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_low  <= '0;
            r_key_high <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_KEY_LOW:  r_key_low  <= i_cfg_data;
                CFG_KEY_HIGH: r_key_high <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign full   = front_busy || clearing;
    assign accept = push && !full;
    assign empty  = !out_valid;

    sacv_front #(.TABLE_SLOTS(TABLE_SLOTS), .SW(SW)) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_frame_length (i_frame_length),
        .i_ip_protocol  (i_ip_protocol),
        .i_syn_flag     (i_syn_flag),
        .i_ack_flag     (i_ack_flag),
        .i_source_ip    (i_source_ip),
        .i_source_port  (i_source_port),
        .i_ack_number   (i_ack_number),
        .i_key_low      (r_key_low),
        .i_key_high     (r_key_high),
        .i_credit_ret   (q_pop),
        .o_busy         (front_busy),
        .o_q_push       (fq_push),
        .o_q_item       (fq_item),
        .o_q_slot       (fq_slot)
    );

    sacv_queue #(.WIDTH(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fq_push),
        .i_data  ({fq_item, fq_slot}),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_data  (q_data)
    );

    sacv_back #(.TABLE_SLOTS(TABLE_SLOTS), .SW(SW)) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_empty     (q_empty),
        .i_q_item      (t_item'(q_data[QW-1:SW])),
        .i_q_slot      (q_data[SW-1:0]),
        .o_q_pop       (q_pop),
        .o_clearing    (clearing),
        .o_valid       (out_valid),
        .i_pop         (pop),
        .o_verdict     (o_verdict),
        .o_port_open   (o_port_open),
        .o_open_ip     (o_open_ip),
        .o_open_port   (o_open_port),
        .o_reply_count (o_reply_count),
        .o_open_count  (o_open_count)
    );
endmodule

FILE: tb/sv/syn_ack_cookie_validator_test.sv
// Self-checking testbench for syn_ack_cookie_validator: queue-style driver and monitor,
// a local cookie hash and seen-table model, and directed then random frame headers.
// Depends on sacv_pkg and the RTL under rtl/core.
module syn_ack_cookie_validator_test
    import sacv_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS       = 4096;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE      = 30;

    typedef struct packed {
        logic [11:0] len;
        logic [7:0]  proto;
        logic        syn;
        logic        ack;
        logic [31:0] ip;
        logic [15:0] port;
        logic [31:0] ackno;
    } frame_t;

    typedef struct packed {
        t_verdict    verdict;
        logic        port_open;
        logic [31:0] ip;
        logic [15:0] port;
        logic [31:0] replies;
        logic [31:0] opens;
    } verdict_rec_t;

    typedef struct packed {
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] c;
        logic [63:0] d;
    } sip_lanes_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        push;
    logic        full;
    logic [11:0] i_frame_length;
    logic [7:0]  i_ip_protocol;
    logic        i_syn_flag;
    logic        i_ack_flag;
    logic [31:0] i_source_ip;
    logic [15:0] i_source_port;
    logic [31:0] i_ack_number;
    logic        empty;
    logic        pop;
    logic [2:0]  o_verdict;
    logic        o_port_open;
    logic [31:0] o_open_ip;
    logic [15:0] o_open_port;
    logic [31:0] o_reply_count;
    logic [31:0] o_open_count;
    logic        i_cfg_we;
    logic        i_cfg_addr;
    logic [63:0] i_cfg_data;

    syn_ack_cookie_validator #(.TABLE_SLOTS(SLOTS)) i_dut (.*);

    // Model state: keys, seen table, replacement pointer, counters
    logic [63:0]  key_lo;
    logic [63:0]  key_hi;
    logic [47:0]  seen_tab [SLOTS][4] = '{default: '0};
    logic [1:0]   way_ptr = '0;
    logic [31:0]  replies = '0;
    logic [31:0]  opens = '0;

    frame_t       pending_frames[$];
    verdict_rec_t verdicts_due[$];
    logic [31:0]  pool_ip [32];
    logic [15:0]  pool_port [32];
    int           send_idle;
    int           recv_idle;
    int           errors = 0;
    int           cycles = 0;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [63:0] rol64(logic [63:0] x, int n);
        return (x << n) | (x >> (64 - n));
    endfunction

    function automatic sip_lanes_t mix_round(sip_lanes_t s);
        s.a += s.b; s.b = rol64(s.b, 13); s.b ^= s.a; s.a = rol64(s.a, 32);
        s.c += s.d; s.d = rol64(s.d, 16); s.d ^= s.c;
        s.a += s.d; s.d = rol64(s.d, 21); s.d ^= s.a;
        s.c += s.b; s.b = rol64(s.b, 17); s.b ^= s.c; s.c = rol64(s.c, 32);
        return s;
    endfunction

    // Expected acknowledgment number for one address/port pair
    function automatic logic [31:0] cookie_ack(logic [47:0] pair);
        sip_lanes_t  s;
        logic [63:0] m;
        logic [63:0] h;
        m   = {16'd0, pair};
        s.a = key_lo ^ 64'h736f6d6570736575;
        s.b = key_hi ^ 64'h646f72616e646f6d;
        s.c = key_lo ^ 64'h6c7967656e657261;
        s.d = key_hi ^ 64'h7465646279746573 ^ m;
        s = mix_round(s);
        s = mix_round(s);
        s.a ^= m;
        s.c ^= 64'hff;
        for (int r = 0; r < 4; r++) s = mix_round(s);
        h = s.a ^ s.b ^ s.c ^ s.d;
        return h[31:0] + 32'd1;
    endfunction

    // Verdict and counters for one accepted frame; updates model state
    function automatic verdict_rec_t judge_frame(frame_t f);
        verdict_rec_t r;
        logic [47:0]  pair;
        int           slot;
        logic         hit;
        r = '0;
        pair = {f.ip, f.port};
        if (f.len < 12'd54 || f.proto != 8'd6) begin
            r.verdict = VERDICT_IGNORED;
        end else if (!f.syn || !f.ack) begin
            r.verdict = VERDICT_NOT_SYNACK;
        end else begin
            if (replies != 32'hffffffff) replies++;
            if (f.ackno != cookie_ack(pair)) begin
                r.verdict = VERDICT_BAD_COOKIE;
            end else begin
                slot = int'(pair % SLOTS);
                hit = 1'b0;
                for (int w = 0; w < 4; w++) if (seen_tab[slot][w] == pair) hit = 1'b1;
                if (hit) begin
                    r.verdict = VERDICT_DUPLICATE;
                end else begin
                    seen_tab[slot][way_ptr] = pair;
                    way_ptr++;
                    if (opens != 32'hffffffff) opens++;
                    r.verdict   = VERDICT_NEW_OPEN;
                    r.port_open = 1'b1;
                    r.ip        = f.ip;
                    r.port      = f.port;
                end
            end
        end
        r.replies = replies;
        r.opens   = opens;
        return r;
    endfunction

    function automatic frame_t syn_ack(logic [31:0] ip, logic [15:0] port, logic good);
        frame_t f;
        f.len   = 12'($urandom_range(54, 1518));
        f.proto = 8'd6;
        f.syn   = 1'b1;
        f.ack   = 1'b1;
        f.ip    = ip;
        f.port  = port;
        f.ackno = good ? cookie_ack({ip, port}) : 32'($urandom());
        return f;
    endfunction

    // Random frame: mostly valid SYN-ACKs, some repeats, bad cookies and noise
    function automatic frame_t random_frame();
        frame_t f;
        int     roll;
        int     p;
        roll = $urandom_range(99);
        p = $urandom_range(31);
        if (roll < 45) begin
            f = syn_ack($urandom(), 16'($urandom()), 1'b1);
            f.len = 12'($urandom_range(54, 4095));
        end else if (roll < 65) begin
            f = syn_ack(pool_ip[p], pool_port[p], 1'b1);
        end else if (roll < 78) begin
            f = syn_ack($urandom(), 16'($urandom()), 1'b0);
        end else begin
            f = frame_t'({6'($urandom()), $urandom(), $urandom(), $urandom()});
            if ($urandom_range(1)) f.proto = 8'd6;
        end
        return f;
    endfunction

    task automatic write_key(logic idx, logic [63:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= val;
        if (idx == CFG_KEY_LOW) key_lo = val;
        else key_hi = val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic drain();
        while (pending_frames.size() != 0 || verdicts_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Driver: transfer on push && !full, then offer the next pending frame
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push           <= 1'b0;
            i_frame_length <= '0;
            i_ip_protocol  <= '0;
            i_syn_flag     <= 1'b0;
            i_ack_flag     <= 1'b0;
            i_source_ip    <= '0;
            i_source_port  <= '0;
            i_ack_number   <= '0;
        end else begin
            if (push && !full) verdicts_due.push_back(judge_frame(pending_frames.pop_front()));
            if (pending_frames.size() != 0 && $urandom_range(99) >= send_idle) begin
                push           <= 1'b1;
                i_frame_length <= pending_frames[0].len;
                i_ip_protocol  <= pending_frames[0].proto;
                i_syn_flag     <= pending_frames[0].syn;
                i_ack_flag     <= pending_frames[0].ack;
                i_source_ip    <= pending_frames[0].ip;
                i_source_port  <= pending_frames[0].port;
                i_ack_number   <= pending_frames[0].ackno;
            end else begin
                push <= 1'b0;
            end
        end
    end

    // Monitor: compare each result transfer with the oldest expected verdict
    always @(posedge i_clk) begin : monitor
        verdict_rec_t e;
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (verdicts_due.size() == 0) begin
                    $error("unexpected result, verdict %0d", o_verdict);
                    errors++;
                end else begin
                    e = verdicts_due.pop_front();
                    if (o_verdict != e.verdict) begin
                        $error("verdict: expected %0d, got %0d", e.verdict, o_verdict);
                        errors++;
                    end
                    if (o_port_open != e.port_open) begin
                        $error("port_open: expected %0d, got %0d", e.port_open, o_port_open);
                        errors++;
                    end
                    if (o_open_ip != e.ip) begin
                        $error("open_ip: expected %h, got %h", e.ip, o_open_ip);
                        errors++;
                    end
                    if (o_open_port != e.port) begin
                        $error("open_port: expected %h, got %h", e.port, o_open_port);
                        errors++;
                    end
                    if (o_reply_count != e.replies) begin
                        $error("reply_count: expected %0d, got %0d", e.replies, o_reply_count);
                        errors++;
                    end
                    if (o_open_count != e.opens) begin
                        $error("open_count: expected %0d, got %0d", e.opens, o_open_count);
                        errors++;
                    end
                end
            end
            pop <= ($urandom_range(99) >= recv_idle);
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Stimulus and phase sequencing
    initial begin
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_addr     = CFG_KEY_LOW;
        i_cfg_data     = '0;
        key_lo = '0; key_hi = '0;
        send_idle = 17; recv_idle = 64;
        foreach (pool_ip[i]) begin
            pool_ip[i]   = $urandom();
            pool_port[i] = 16'($urandom());
        end
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Zero keys, written during the post-reset sweep
        write_key(CFG_KEY_LOW, 64'd0);
        write_key(CFG_KEY_HIGH, 64'd0);

        // Directed: screening limits, flags, zero pair, bad cookie, way replacement
        pending_frames.push_back(frame_t'{12'd53, 8'd6, 1'b1, 1'b1, 32'd1, 16'd1, 32'd0});
        pending_frames.push_back(frame_t'{12'd0, 8'd6, 1'b1, 1'b1, 32'd1, 16'd1, 32'd0});
        pending_frames.push_back(frame_t'{12'd4095, 8'd5, 1'b1, 1'b1, 32'd1, 16'd1, 32'd0});
        pending_frames.push_back(frame_t'{12'd60, 8'd7, 1'b1, 1'b1, 32'd1, 16'd1, 32'd0});
        pending_frames.push_back(frame_t'{12'd60, 8'd255, 1'b1, 1'b1, 32'd1, 16'd1, 32'd0});
        pending_frames.push_back(frame_t'{12'd54, 8'd6, 1'b0, 1'b0, 32'd1, 16'd1, 32'd0});
        pending_frames.push_back(frame_t'{12'd54, 8'd6, 1'b1, 1'b0, 32'd1, 16'd1, 32'd0});
        pending_frames.push_back(frame_t'{12'd54, 8'd6, 1'b0, 1'b1, 32'd1, 16'd1, 32'd0});
        pending_frames.push_back(syn_ack(32'd0, 16'd0, 1'b1));
        pending_frames.push_back(syn_ack(32'hffffffff, 16'hffff, 1'b1));
        pending_frames.push_back(syn_ack(32'hffffffff, 16'hffff, 1'b1));
        pending_frames.push_back(syn_ack(32'h0a000001, 16'd80, 1'b0));
        begin : directed
            frame_t f;
            f = syn_ack(32'h0a000001, 16'd443, 1'b1);
            f.len = 12'd2048;
            pending_frames.push_back(f);
            f.ackno = f.ackno ^ 32'h1;
            pending_frames.push_back(f);
            f.ackno = 32'hffffffff;
            pending_frames.push_back(f);
        end
        // Five pairs in one slot evict the first; its repeat is new again
        for (int i = 1; i <= 5; i++) pending_frames.push_back(syn_ack(i, 16'h0123, 1'b1));
        pending_frames.push_back(syn_ack(32'd1, 16'h0123, 1'b1));
        pending_frames.push_back(syn_ack(32'd5, 16'h0123, 1'b1));
        drain();

        // Random, all-ones keys
        write_key(CFG_KEY_LOW, 64'hffffffffffffffff);
        write_key(CFG_KEY_HIGH, 64'hffffffffffffffff);
        repeat (240) pending_frames.push_back(random_frame());
        drain();

        // Random keys, idling swapped
        send_idle = 64; recv_idle = 17;
        write_key(CFG_KEY_LOW, {$urandom(), $urandom()});
        write_key(CFG_KEY_HIGH, {$urandom(), $urandom()});
        repeat (230) pending_frames.push_back(random_frame());
        drain();

        // Random low key, zero high key, no idling
        send_idle = 0; recv_idle = 0;
        write_key(CFG_KEY_LOW, {$urandom(), $urandom()});
        write_key(CFG_KEY_HIGH, 64'd0);
        repeat (230) pending_frames.push_back(random_frame());
        drain();

        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/core/sacv_pkg.sv
rtl/core/sacv_queue.sv
rtl/core/sacv_front.sv
rtl/core/sacv_back.sv
rtl/core/syn_ack_cookie_validator.sv
tb/sv/syn_ack_cookie_validator_test.sv
